// ===== sv/spev_pkg.sv =====
package spev_pkg;

	localparam int unsigned SPRITE_COUNT_DEF = 64;
	localparam int unsigned MAX_PER_LINE_DEF = 8;
	localparam int unsigned RESULT_CAP = 8;
	localparam int unsigned STORE_DEPTH = 256;

	localparam logic [7:0] ATTR_MASK = 8'hE3;
	localparam logic [7:0] SHORT_HEIGHT = 8'd8;
	localparam logic [7:0] TALL_HEIGHT = 8'd16;

	localparam logic [2:0] MODE_SET_PTR = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_READ = 3'd2;
	localparam logic [2:0] MODE_EVAL = 3'd3;
	localparam logic [2:0] MODE_CLR_PTR = 3'd4;

	// byte offsets within one sprite entry
	localparam logic [1:0] OFF_Y = 2'd0;
	localparam logic [1:0] OFF_TILE = 2'd1;
	localparam logic [1:0] OFF_ATTR = 2'd2;
	localparam logic [1:0] OFF_X = 2'd3;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_DONE,
		OUT_READ,
		OUT_REC_MID,
		OUT_REC_LAST,
		OUT_EMPTY
	} out_op_t;

	typedef struct packed {
		logic acc;
		logic eval_clr;
		logic rd_en;
		logic [1:0] rd_off;
		logic cap_y;
		logic cap_tile;
		logic cap_attr;
		logic cap_x;
		logic idx_inc;
		logic cnt_inc;
		logic set_ovf;
		out_op_t out_op;
	} cmd_t;

	typedef struct packed {
		logic mode_eval;
		logic mode_read;
		logic hit;
		logic cnt_full;
		logic cnt_zero;
		logic idx_end;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/sprite_attribute_store_and_line_eval.sv =====
// Sprite attribute store with per-scanline sprite evaluation.
// Input channel (in_valid/in_ready) carries mode, write_value and scanline;
// output channel (out_valid/out_ready) carries one result per register load.
// cfg_we/cfg_wdata set the tall-sprite select; write only while idle.
// Set pointer, write, clear and unused modes: one result with last set,
// loaded at the edge that takes the item and valid in the next cycle.
// Read: the byte passes the store's registered read port, then the result register.
// Evaluate: the store is read one byte at a time; for each sprite the Y byte
// is read and checked against the scanline, and for a sprite in range the
// tile, attribute and X bytes are then read in turn. Sprites are looked at
// in index order (64 by default); a sprite in range found once the limit
// (8 by default) is reached raises overflow and stops the scan.
// Each found sprite is held until the next one is found or the scan ends, so
// that last and overflow can be set on the final result.
// One item is processed at a time; in_ready is high in idle when the output
// register is empty or being emptied. A stalled receiver holds the result
// register and the scan waits at the next result it has to hand over.
// Reset clears pointer, tall select and every byte of the store (per-byte
// valid bits), so the block is usable in the first cycle after reset.
module sprite_attribute_store_and_line_eval #(
	parameter int unsigned SPRITE_COUNT = spev_pkg::SPRITE_COUNT_DEF,
	parameter int unsigned MAX_PER_LINE = spev_pkg::MAX_PER_LINE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] mode,
	input  logic [7:0] write_value,
	input  logic [7:0] scanline,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       sprite_found,
	output logic [5:0] sprite_number,
	output logic [7:0] sprite_y,
	output logic [7:0] sprite_tile,
	output logic [7:0] sprite_attr,
	output logic [7:0] sprite_x,
	output logic       overflow,
	output logic       last
);
	import spev_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spev_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spev_dp #(
		.SPRITE_COUNT (SPRITE_COUNT),
		.MAX_PER_LINE (MAX_PER_LINE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.mode          (mode),
		.write_value   (write_value),
		.scanline      (scanline),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.read_data     (read_data),
		.sprite_found  (sprite_found),
		.sprite_number (sprite_number),
		.sprite_y      (sprite_y),
		.sprite_tile   (sprite_tile),
		.sprite_attr   (sprite_attr),
		.sprite_x      (sprite_x),
		.overflow      (overflow),
		.last          (last)
	);

endmodule

// ===== sv/spev_dp.sv =====
module spev_dp #(
	parameter int unsigned SPRITE_COUNT = 64,
	parameter int unsigned MAX_PER_LINE = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spev_pkg::cmd_t    cmd,
	output spev_pkg::sts_t    sts,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic [2:0]        mode,
	input  logic [7:0]        write_value,
	input  logic [7:0]        scanline,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_data,
	output logic              sprite_found,
	output logic [5:0]        sprite_number,
	output logic [7:0]        sprite_y,
	output logic [7:0]        sprite_tile,
	output logic [7:0]        sprite_attr,
	output logic [7:0]        sprite_x,
	output logic              overflow,
	output logic              last
);
	import spev_pkg::*;

	localparam int unsigned LIMIT = (MAX_PER_LINE < RESULT_CAP) ? MAX_PER_LINE : RESULT_CAP;
	localparam int unsigned CNT_W = $clog2(LIMIT + 1);

	logic [7:0]       mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [7:0]       mem_rd_q;
	logic             vld_rd_q;
	logic [7:0]       rdata;
	logic [7:0]       rd_addr;
	logic             mem_re;
	logic             mem_we;
	logic [7:0]       wdata;

	logic [7:0]       ptr_q;
	logic             tall_q;
	logic [7:0]       line_q;
	logic [5:0]       idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;

	logic [5:0]       rec_num_q;
	logic [7:0]       rec_y_q;
	logic [7:0]       rec_tile_q;
	logic [7:0]       rec_attr_q;
	logic [7:0]       rec_x_q;

	logic [7:0]       diff;
	logic [7:0]       height;

	assign mem_we = cmd.acc && (mode == MODE_WRITE);
	assign mem_re = (cmd.acc && (mode == MODE_READ)) || cmd.rd_en;
	assign rd_addr = cmd.rd_en ? {idx_q, cmd.rd_off} : ptr_q;
	assign wdata = (ptr_q[1:0] == OFF_ATTR) ? (write_value & ATTR_MASK) : write_value;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[ptr_q] <= wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem_q[rd_addr];
		end
	end

	// never-written bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[ptr_q] <= 1'b1;
			end
			if (mem_re) begin
				vld_rd_q <= vld_q[rd_addr];
			end
		end
	end

	assign rdata = vld_rd_q ? mem_rd_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			tall_q <= 1'b0;
			idx_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				tall_q <= cfg_wdata;
			end
			if (cmd.acc) begin
				unique case (mode)
					MODE_SET_PTR: ptr_q <= write_value;
					MODE_WRITE:   ptr_q <= ptr_q + 8'd1;
					MODE_CLR_PTR: ptr_q <= '0;
					default:      ptr_q <= ptr_q;
				endcase
			end
			if (cmd.eval_clr) begin
				idx_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (cmd.idx_inc) begin
					idx_q <= idx_q + 6'd1;
				end
				if (cmd.cnt_inc) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (cmd.set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.out_op != OUT_NONE) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			line_q <= scanline;
		end
		if (cmd.cap_y) begin
			rec_num_q <= idx_q;
			rec_y_q <= rdata;
		end
		if (cmd.cap_tile) begin
			rec_tile_q <= rdata;
		end
		if (cmd.cap_attr) begin
			rec_attr_q <= rdata;
		end
		if (cmd.cap_x) begin
			rec_x_q <= rdata;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.out_op)
			OUT_DONE, OUT_READ, OUT_EMPTY: begin
				read_data <= (cmd.out_op == OUT_READ) ? rdata : 8'd0;
				sprite_found <= 1'b0;
				sprite_number <= '0;
				sprite_y <= '0;
				sprite_tile <= '0;
				sprite_attr <= '0;
				sprite_x <= '0;
				overflow <= (cmd.out_op == OUT_EMPTY) ? ovf_q : 1'b0;
				last <= 1'b1;
			end
			OUT_REC_MID, OUT_REC_LAST: begin
				read_data <= 8'd0;
				sprite_found <= 1'b1;
				sprite_number <= rec_num_q;
				sprite_y <= rec_y_q;
				sprite_tile <= rec_tile_q;
				sprite_attr <= rec_attr_q;
				sprite_x <= rec_x_q;
				overflow <= (cmd.out_op == OUT_REC_LAST) ? ovf_q : 1'b0;
				last <= (cmd.out_op == OUT_REC_LAST);
			end
			default: begin
			end
		endcase
	end

	// Y byte is in rdata while the controller checks it
	assign height = tall_q ? TALL_HEIGHT : SHORT_HEIGHT;
	assign diff = line_q - rdata;

	assign sts.mode_eval = (mode == MODE_EVAL);
	assign sts.mode_read = (mode == MODE_READ);
	assign sts.hit = (line_q >= rdata) && (diff < height);
	assign sts.cnt_full = (cnt_q == CNT_W'(LIMIT));
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.idx_end = (idx_q == 6'(SPRITE_COUNT - 1));
	assign sts.out_free = !out_valid || out_ready;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LIMIT))
		else $error("found count above limit");

	a_ptr_adv: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> ptr_q == $past(ptr_q + 8'd1))
		else $error("pointer did not advance after data write");

	a_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sprite_number) && $stable(last)))
		else $error("stalled result changed");
`endif

endmodule

// ===== sv/spev_ctrl.sv =====
module spev_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  spev_pkg::sts_t sts,
	output spev_pkg::cmd_t cmd
);
	import spev_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RD   = 8'b0000_0010,
		ST_YREQ = 8'b0000_0100,
		ST_YCHK = 8'b0000_1000,
		ST_TILE = 8'b0001_0000,
		ST_ATTR = 8'b0010_0000,
		ST_XB   = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;

	always_comb begin
		cmd = '0;
		cmd.out_op = OUT_NONE;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.acc = 1'b1;
					if (sts.mode_eval) begin
						cmd.eval_clr = 1'b1;
						state_d = ST_YREQ;
					end else if (sts.mode_read) begin
						state_d = ST_RD;
					end else begin
						cmd.out_op = OUT_DONE;
					end
				end
			end
			ST_RD: begin
				cmd.out_op = OUT_READ;
				state_d = ST_IDLE;
			end
			ST_YREQ: begin
				cmd.rd_en = 1'b1;
				cmd.rd_off = OFF_Y;
				state_d = ST_YCHK;
			end
			ST_YCHK: begin
				if (!sts.hit) begin
					if (sts.idx_end) begin
						state_d = ST_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d = ST_YREQ;
					end
				end else if (sts.cnt_full) begin
					cmd.set_ovf = 1'b1;
					state_d = ST_FIN;
				end else if (sts.cnt_zero || sts.out_free) begin
					// a held sprite goes out now that another one follows it
					if (!sts.cnt_zero) begin
						cmd.out_op = OUT_REC_MID;
					end
					cmd.cap_y = 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_off = OFF_TILE;
					state_d = ST_TILE;
				end
			end
			ST_TILE: begin
				cmd.cap_tile = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_off = OFF_ATTR;
				state_d = ST_ATTR;
			end
			ST_ATTR: begin
				cmd.cap_attr = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_off = OFF_X;
				state_d = ST_XB;
			end
			ST_XB: begin
				cmd.cap_x = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.idx_end) begin
					state_d = ST_FIN;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = ST_YREQ;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_op = sts.cnt_zero ? OUT_EMPTY : OUT_REC_LAST;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_op != OUT_NONE) |-> sts.out_free)
		else $error("result loaded over a waiting one");

	a_ovf_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_ovf |-> (sts.hit && sts.cnt_full && state_q == ST_YCHK))
		else $error("overflow raised without a sprite past the limit");

	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc && sts.mode_eval) |=> (state_q == ST_YREQ))
		else $error("scan did not start after evaluate item");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import spev_pkg::*;

	localparam int N_SPRITES = int'(SPRITE_COUNT_DEF);
	localparam int LINE_LIMIT = int'(MAX_PER_LINE_DEF);
	localparam int HIT_CAP = (LINE_LIMIT < int'(RESULT_CAP)) ? LINE_LIMIT : int'(RESULT_CAP);
	localparam logic [2:0] MODE_SPARE_LO = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [7:0] rd;
		logic       found;
		logic [5:0] num;
		logic [7:0] y;
		logic [7:0] tile;
		logic [7:0] attr;
		logic [7:0] x;
		logic       ovf;
		logic       last;
	} sprite_result_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] mode;
	logic [7:0] write_value;
	logic [7:0] scanline;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic       sprite_found;
	logic [5:0] sprite_number;
	logic [7:0] sprite_y;
	logic [7:0] sprite_tile;
	logic [7:0] sprite_attr;
	logic [7:0] sprite_x;
	logic       overflow;
	logic       last;

	// shadow of the block's state
	logic [7:0] oam_copy [STORE_DEPTH];
	logic [7:0] ptr_copy;
	logic       tall_copy;

	sprite_result_t awaited_results [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int sink_hold = 0;
	bit no_idle = 0;
	logic [7:0] hot_line;

	sprite_attribute_store_and_line_eval #(
		.SPRITE_COUNT(N_SPRITES),
		.MAX_PER_LINE(LINE_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.write_value(write_value),
		.scanline(scanline),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.sprite_found(sprite_found),
		.sprite_number(sprite_number),
		.sprite_y(sprite_y),
		.sprite_tile(sprite_tile),
		.sprite_attr(sprite_attr),
		.sprite_x(sprite_x),
		.overflow(overflow),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 3) == 0) begin
			return 0;
		end
		return $urandom_range(0, 12);
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatch_count < 30) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	// four-state compare so that unknown outputs are caught
	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
		end
	endtask

	// Expected results of one accepted item; updates the shadow state.
	task automatic compute_line_results(logic [2:0] m, logic [7:0] wv, logic [7:0] sl);
		sprite_result_t rows [RESULT_CAP];
		sprite_result_t r;
		int hits;
		int height;
		int diff;
		int i;
		bit over;
		logic [7:0] base;

		r = '0;
		if (m == MODE_EVAL) begin
			height = tall_copy ? int'(TALL_HEIGHT) : int'(SHORT_HEIGHT);
			hits = 0;
			over = 0;
			i = 0;
			while (i < N_SPRITES && !over) begin
				base = 8'(i * 4);
				diff = int'(sl) - int'(oam_copy[base]);
				if (diff >= 0 && diff < height) begin
					if (hits >= HIT_CAP) begin
						over = 1;
					end else begin
						rows[hits] = '0;
						rows[hits].found = 1'b1;
						rows[hits].num = 6'(i);
						rows[hits].y = oam_copy[base];
						rows[hits].tile = oam_copy[8'(base + 8'd1)];
						rows[hits].attr = oam_copy[8'(base + 8'd2)];
						rows[hits].x = oam_copy[8'(base + 8'd3)];
						hits++;
					end
				end
				i++;
			end
			if (hits == 0) begin
				rows[0] = '0;
				hits = 1;
			end
			rows[hits - 1].ovf = over;
			rows[hits - 1].last = 1'b1;
			for (i = 0; i < hits; i++) begin
				awaited_results.push_back(rows[i]);
			end
		end else begin
			r.last = 1'b1;
			case (m)
				MODE_SET_PTR: ptr_copy = wv;
				MODE_WRITE: begin
					oam_copy[ptr_copy] = (ptr_copy[1:0] == OFF_ATTR) ? (wv & ATTR_MASK) : wv;
					ptr_copy = ptr_copy + 8'd1;
				end
				MODE_READ: r.rd = oam_copy[ptr_copy];
				MODE_CLR_PTR: ptr_copy = '0;
				default: ;
			endcase
			awaited_results.push_back(r);
		end
	endtask

	// Called at a clock edge; returns at the edge the item was taken.
	task automatic send_item(logic [2:0] m, logic [7:0] wv, logic [7:0] sl);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		write_value <= wv;
		scanline <= sl;
		do begin
			@(posedge clk);
		end while (in_ready !== 1'b1);
		compute_line_results(m, wv, sl);
		if (m <= MODE_CLR_PTR) begin
			items_sent++;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tall(logic v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tall_copy = v;
		cfg_we <= 1'b0;
	endtask

	task automatic write_record(logic [7:0] base, logic [7:0] y);
		send_item(MODE_SET_PTR, base, 8'($urandom));
		send_item(MODE_WRITE, y, 8'($urandom));
		send_item(MODE_WRITE, 8'($urandom), 8'($urandom));
		send_item(MODE_WRITE, 8'($urandom), 8'($urandom));
		send_item(MODE_WRITE, 8'($urandom), 8'($urandom));
	endtask

	function automatic logic [7:0] near_hot_y();
		if ($urandom_range(0, 9) < 7) begin
			return hot_line + 8'($urandom_range(0, 15));
		end
		return 8'($urandom);
	endfunction

	task automatic test_reset_contents();
		send_item(MODE_READ, 8'h00, 8'h00);
		// every sprite sits at Y 0: limit reached plus overflow
		send_item(MODE_EVAL, 8'hFF, 8'h00);
		send_item(MODE_EVAL, 8'h00, 8'hFF);
	endtask

	task automatic test_pointer_and_mask();
		send_item(MODE_SET_PTR, 8'hFF, 8'h00);
		send_item(MODE_WRITE, 8'hA5, 8'hFF);
		send_item(MODE_READ, 8'h00, 8'h00);
		send_item(MODE_SET_PTR, 8'hFF, 8'h00);
		send_item(MODE_READ, 8'hFF, 8'hFF);
		send_item(MODE_CLR_PTR, 8'hFF, 8'hFF);
		send_item(MODE_READ, 8'h00, 8'h00);
		send_item(MODE_SET_PTR, 8'h02, 8'h00);
		send_item(MODE_WRITE, 8'hFF, 8'h00);
		send_item(MODE_SET_PTR, 8'h02, 8'h00);
		send_item(MODE_READ, 8'h00, 8'h00);
		send_item(MODE_SPARE_LO, 8'hFF, 8'hFF);
		send_item(MODE_SPARE_HI, 8'h00, 8'h00);
	endtask

	task automatic test_line_edges();
		send_item(MODE_SET_PTR, 8'h00, 8'h00);
		send_item(MODE_WRITE, 8'hFF, 8'h00);
		send_item(MODE_EVAL, 8'h00, 8'hFF);
		send_item(MODE_EVAL, 8'h00, 8'd7);
		send_item(MODE_EVAL, 8'h00, 8'd8);
		set_tall(1'b1);
		send_item(MODE_EVAL, 8'h00, 8'd15);
		send_item(MODE_EVAL, 8'h00, 8'd16);
		send_item(MODE_EVAL, 8'h00, 8'hFF);
	endtask

	// Rewrite every Y byte; a handful land near the hot line.
	task automatic test_table_load();
		int s;
		logic [7:0] y;
		for (s = 0; s < N_SPRITES; s++) begin
			if ($urandom_range(0, 63) < 12) begin
				y = hot_line + 8'($urandom_range(0, 15));
			end else begin
				y = 8'($urandom);
			end
			send_item(MODE_SET_PTR, 8'(s * 4), 8'($urandom));
			send_item(MODE_WRITE, y, 8'($urandom));
		end
	endtask

	task automatic test_random_traffic(int n);
		int start;
		int pick;
		logic [7:0] base;
		logic [7:0] sl;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// mostly aligned records, some starting mid-sprite
				if (pick < 40) begin
					base = 8'($urandom_range(0, N_SPRITES - 1) * 4);
				end else begin
					base = 8'($urandom);
				end
				write_record(base, near_hot_y());
			end else if (pick < 75) begin
				if ($urandom_range(0, 2) != 0) begin
					sl = hot_line + 8'($urandom_range(0, 20));
				end else begin
					sl = 8'($urandom);
				end
				send_item(MODE_EVAL, 8'($urandom), sl);
			end else if (pick < 88) begin
				send_item(MODE_SET_PTR, 8'($urandom), 8'($urandom));
				send_item(MODE_READ, 8'($urandom), 8'($urandom));
			end else begin
				send_item(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	// receiver: after each taken result, hold ready low for a drawn count
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			sink_hold = draw_wait();
		end
		if (sink_hold > 0) begin
			sink_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		sprite_result_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with nothing awaited");
			end else begin
				want = awaited_results.pop_front();
				check_field("read_data", 32'(read_data), 32'(want.rd));
				check_field("sprite_found", 32'(sprite_found), 32'(want.found));
				check_field("sprite_number", 32'(sprite_number), 32'(want.num));
				check_field("sprite_y", 32'(sprite_y), 32'(want.y));
				check_field("sprite_tile", 32'(sprite_tile), 32'(want.tile));
				check_field("sprite_attr", 32'(sprite_attr), 32'(want.attr));
				check_field("sprite_x", 32'(sprite_x), 32'(want.x));
				check_field("overflow", 32'(overflow), 32'(want.ovf));
				check_field("last", 32'(last), 32'(want.last));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		mode = MODE_SET_PTR;
		write_value = 8'h00;
		scanline = 8'h00;
		for (int a = 0; a < int'(STORE_DEPTH); a++) begin
			oam_copy[a] = 8'h00;
		end
		ptr_copy = 8'h00;
		tall_copy = 1'b0;
		hot_line = 8'($urandom_range(20, 200));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_contents();
		test_pointer_and_mask();
		test_line_edges();

		set_tall(1'b0);
		test_table_load();
		test_random_traffic(60);
		set_tall(1'b1);
		no_idle = 1;
		test_random_traffic(60);
		no_idle = 0;
		set_tall(1'b0);
		test_random_traffic(60);
		set_tall(1'b1);
		test_random_traffic(50);

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
